[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is applied
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication built on the clocked form
`define ASSERT_IMPLY(label, lhs, rhs, msg) \
    `ASSERT_CLK(label, (lhs) |-> (rhs), msg)

`endif

[sv/i2p_pkg.sv]
`timescale 1ns / 1ps

package i2p_pkg;

    // Stack entry codes
    typedef logic [2:0] op_code_t;
    localparam op_code_t CODE_NONE  = 3'd0;
    localparam op_code_t CODE_OPEN  = 3'd1;
    localparam op_code_t CODE_HASH  = 3'd2;
    localparam op_code_t CODE_AT    = 3'd3;
    localparam op_code_t CODE_AMP   = 3'd4;
    localparam op_code_t CODE_SLASH = 3'd5;
    localparam op_code_t CODE_CARET = 3'd6;

    // Status codes
    typedef logic [2:0] status_t;
    localparam status_t STS_OK        = 3'd0;
    localparam status_t STS_FULL      = 3'd1;
    localparam status_t STS_UNMATCHED = 3'd2;
    localparam status_t STS_INVALID   = 3'd3;
    localparam status_t STS_UNCLOSED  = 3'd4;

    // Characters
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_OPEN    = 8'h28;
    localparam logic [7:0] CH_CLOSE   = 8'h29;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_CARET   = 8'h5E;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_TERM = 3'b100
    } state_t;

    typedef enum logic [1:0] {
        MODE_OP,
        MODE_CLOSE,
        MODE_FLUSH
    } mode_t;

    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_ALNUM,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_OPER,
        CLS_NEWLINE,
        CLS_INVALID
    } sym_class_t;

    function automatic sym_class_t sym_class(input logic [7:0] c);
        sym_class_t cls;
        case (c) inside
            CH_SPACE:                                     cls = CLS_SPACE;
            [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]: cls = CLS_ALNUM;
            CH_OPEN:                                      cls = CLS_OPEN;
            CH_CLOSE:                                     cls = CLS_CLOSE;
            CH_HASH, CH_AT, CH_AMP, CH_SLASH, CH_CARET:   cls = CLS_OPER;
            CH_NEWLINE:                                   cls = CLS_NEWLINE;
            default:                                      cls = CLS_INVALID;
        endcase
        return cls;
    endfunction

    function automatic op_code_t op_code_of(input logic [7:0] c);
        op_code_t code;
        case (c)
            CH_HASH:  code = CODE_HASH;
            CH_AT:    code = CODE_AT;
            CH_AMP:   code = CODE_AMP;
            CH_SLASH: code = CODE_SLASH;
            CH_CARET: code = CODE_CARET;
            default:  code = CODE_NONE;
        endcase
        return code;
    endfunction

    function automatic logic [2:0] code_prec(input op_code_t code);
        logic [2:0] p;
        case (code)
            CODE_OPEN:             p = 3'd1;
            CODE_HASH, CODE_AT:    p = 3'd2;
            CODE_AMP, CODE_SLASH:  p = 3'd3;
            CODE_CARET:            p = 3'd4;
            default:               p = 3'd0;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] code_char(input op_code_t code);
        logic [7:0] ch;
        case (code)
            CODE_OPEN:  ch = CH_OPEN;
            CODE_HASH:  ch = CH_HASH;
            CODE_AT:    ch = CH_AT;
            CODE_AMP:   ch = CH_AMP;
            CODE_SLASH: ch = CH_SLASH;
            CODE_CARET: ch = CH_CARET;
            default:    ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

[sv/infix_to_postfix_converter.sv]
`timescale 1ns / 1ps

// Shunting-yard infix to postfix converter, one input character per request.
// Every request yields one or more output requests; last_of_run marks the
// final one, and all outputs of one input carry the same status. Spaces,
// letters, digits, invalid characters, '(' and an unmatched ')' finish
// straight from the idle state, as do an operator or a newline that finds
// the stack empty. Otherwise the operator stack is walked one entry per
// cycle through the single read port of the stack memory (a registered
// read): an operator pops entries of equal or higher precedence, a ')' the
// operators above its '(', and a newline every entry, with a terminating
// step when it emitted operators. A stalled output holds the sequencer in
// place. A new input is taken only when the sequencer is idle and the output
// register is free or being drained. No clearing pass is needed after reset.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       symbol,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_symbol,
    output logic             has_symbol,
    output logic             last_of_run,
    output i2p_pkg::status_t status
);
    import i2p_pkg::*;

`include "assert_macros.svh"

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    // Stack memory
    op_code_t          stack_mem [STACK_DEPTH];
    op_code_t          rd_data_reg;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    op_code_t          wr_data;

    // Sequencer state
    state_t            state_reg, state_next;
    mode_t             mode_reg, mode_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     open_cnt_reg, open_cnt_next;
    op_code_t          code_reg, code_next;
    status_t           status_reg, status_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [7:0]        pend_sym_reg, pend_sym_next;

    // Output register
    logic              out_valid_reg;
    logic [7:0]        out_sym_reg;
    logic              out_has_reg;
    logic              out_last_reg;
    status_t           out_status_reg;
    logic              out_load;
    logic [7:0]        out_sym_d;
    logic              out_has_d;
    logic              out_last_d;
    status_t           out_status_d;

    logic              out_free;
    logic              in_fire;
    logic [CW-1:0]     count_m1;
    logic [CW-1:0]     count_m2;
    status_t           nl_status;
    status_t           op_status;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == S_IDLE) && out_free);
    assign in_fire  = in_valid && !in_stall;
    assign count_m1 = count_reg - ONE_C;
    assign count_m2 = count_reg - TWO_C;
    assign nl_status = (open_cnt_reg != '0) ? STS_UNCLOSED : STS_OK;
    assign op_status = (count_reg == DEPTH_C) ? STS_FULL : STS_OK;

    // Sequencer next state and stack accesses
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        count_next      = count_reg;
        open_cnt_next   = open_cnt_reg;
        code_next       = code_reg;
        status_next     = status_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        out_load        = 1'b0;
        out_sym_d       = CH_NUL;
        out_has_d       = 1'b0;
        out_last_d      = 1'b0;
        out_status_d    = status_reg;
        rd_en           = 1'b0;
        rd_addr         = count_m1[AW-1:0];
        wr_en           = 1'b0;
        wr_addr         = count_reg[AW-1:0];
        wr_data         = code_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    out_last_d   = 1'b1;
                    out_status_d = STS_OK;
                    case (sym_class(symbol))
                        CLS_SPACE:
                        begin
                            out_load = 1'b1;
                        end
                        CLS_ALNUM:
                        begin
                            out_load  = 1'b1;
                            out_sym_d = symbol;
                            out_has_d = 1'b1;
                        end
                        CLS_OPEN:
                        begin
                            out_load = 1'b1;
                            if (count_reg == DEPTH_C)
                            begin
                                out_status_d = STS_FULL;
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                wr_data       = CODE_OPEN;
                                count_next    = count_reg + ONE_C;
                                open_cnt_next = open_cnt_reg + ONE_C;
                            end
                        end
                        CLS_CLOSE:
                        begin
                            if (open_cnt_reg == '0)
                            begin
                                out_load     = 1'b1;
                                out_status_d = STS_UNMATCHED;
                            end
                            else
                            begin
                                rd_en       = 1'b1;
                                mode_next   = MODE_CLOSE;
                                status_next = STS_OK;
                                state_next  = S_POP;
                            end
                        end
                        CLS_OPER:
                        begin
                            code_next = op_code_of(symbol);
                            if (count_reg == '0)
                            begin
                                out_load   = 1'b1;
                                wr_en      = 1'b1;
                                wr_data    = op_code_of(symbol);
                                count_next = ONE_C;
                            end
                            else
                            begin
                                rd_en       = 1'b1;
                                mode_next   = MODE_OP;
                                status_next = STS_OK;
                                state_next  = S_POP;
                            end
                        end
                        CLS_NEWLINE:
                        begin
                            if (count_reg == '0)
                            begin
                                out_load     = 1'b1;
                                out_has_d    = 1'b1;
                                out_status_d = nl_status;
                            end
                            else
                            begin
                                rd_en       = 1'b1;
                                mode_next   = MODE_FLUSH;
                                status_next = nl_status;
                                state_next  = S_POP;
                            end
                        end
                        default:
                        begin
                            out_load     = 1'b1;
                            out_status_d = STS_INVALID;
                        end
                    endcase
                end
            end

            S_POP:
            begin
                if (out_free)
                begin
                    case (mode_reg)
                        MODE_OP:
                        begin
                            if ((count_reg == '0) ||
                                (code_prec(rd_data_reg) < code_prec(code_reg)))
                            begin
                                // End of pops: push the operator unless still full
                                if (count_reg != DEPTH_C)
                                begin
                                    wr_en      = 1'b1;
                                    count_next = count_reg + ONE_C;
                                end
                                out_load        = 1'b1;
                                out_last_d      = 1'b1;
                                out_sym_d       = pend_valid_reg ? pend_sym_reg : CH_NUL;
                                out_has_d       = pend_valid_reg;
                                out_status_d    = pend_valid_reg ? STS_OK : op_status;
                                pend_valid_next = 1'b0;
                                state_next      = S_IDLE;
                            end
                            else
                            begin
                                count_next      = count_m1;
                                rd_en           = 1'b1;
                                rd_addr         = count_m2[AW-1:0];
                                pend_valid_next = 1'b1;
                                pend_sym_next   = code_char(rd_data_reg);
                                out_load        = pend_valid_reg;
                                out_sym_d       = pend_sym_reg;
                                out_has_d       = 1'b1;
                            end
                        end
                        MODE_CLOSE:
                        begin
                            if (rd_data_reg == CODE_OPEN)
                            begin
                                // Matching '(' is dropped without output
                                count_next      = count_m1;
                                open_cnt_next   = open_cnt_reg - ONE_C;
                                out_load        = 1'b1;
                                out_last_d      = 1'b1;
                                out_sym_d       = pend_valid_reg ? pend_sym_reg : CH_NUL;
                                out_has_d       = pend_valid_reg;
                                pend_valid_next = 1'b0;
                                state_next      = S_IDLE;
                            end
                            else
                            begin
                                count_next      = count_m1;
                                rd_en           = 1'b1;
                                rd_addr         = count_m2[AW-1:0];
                                pend_valid_next = 1'b1;
                                pend_sym_next   = code_char(rd_data_reg);
                                out_load        = pend_valid_reg;
                                out_sym_d       = pend_sym_reg;
                                out_has_d       = 1'b1;
                            end
                        end
                        MODE_FLUSH:
                        begin
                            if (count_reg == '0)
                            begin
                                out_load  = 1'b1;
                                out_has_d = 1'b1;
                                if (pend_valid_reg)
                                begin
                                    out_sym_d       = pend_sym_reg;
                                    pend_valid_next = 1'b0;
                                    state_next      = S_TERM;
                                end
                                else
                                begin
                                    out_last_d = 1'b1;
                                    state_next = S_IDLE;
                                end
                            end
                            else if (rd_data_reg == CODE_OPEN)
                            begin
                                // Unclosed '(' is discarded without output
                                count_next    = count_m1;
                                open_cnt_next = open_cnt_reg - ONE_C;
                                rd_en         = 1'b1;
                                rd_addr       = count_m2[AW-1:0];
                            end
                            else
                            begin
                                count_next      = count_m1;
                                rd_en           = 1'b1;
                                rd_addr         = count_m2[AW-1:0];
                                pend_valid_next = 1'b1;
                                pend_sym_next   = code_char(rd_data_reg);
                                out_load        = pend_valid_reg;
                                out_sym_d       = pend_sym_reg;
                                out_has_d       = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_TERM:
            begin
                // Terminating zero after the last flushed operator
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_has_d  = 1'b1;
                    out_last_d = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Stack memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_OP;
            count_reg      <= '0;
            open_cnt_reg   <= '0;
            status_reg     <= STS_OK;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            count_reg      <= count_next;
            open_cnt_reg   <= open_cnt_next;
            status_reg     <= status_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        pend_sym_reg <= pend_sym_next;
        if (out_load)
        begin
            out_sym_reg    <= out_sym_d;
            out_has_reg    <= out_has_d;
            out_last_reg   <= out_last_d;
            out_status_reg <= out_status_d;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_symbol  = out_sym_reg;
    assign has_symbol  = out_has_reg;
    assign last_of_run = out_last_reg;
    assign status      = out_status_reg;

    // Checks
    `ASSERT_CLK(a_open_le_count, open_cnt_reg <= count_reg, "more opens than stack entries")
    `ASSERT_IMPLY(a_close_has_open, (state_reg == S_POP) && (mode_reg == MODE_CLOSE), open_cnt_reg != '0, "close walk without an open on the stack")
    `ASSERT_IMPLY(a_pend_in_pop, pend_valid_reg, state_reg == S_POP, "pending output outside the pop walk")
    `ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= DEPTH_C, "stack count beyond depth")

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import i2p_pkg::*;

    localparam int STACK_DEPTH   = 32;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;

    // One postfix output request as the converter should produce it
    typedef struct {
        logic [7:0] sym;
        logic       has;
        logic       last;
        status_t    st;
    } postfix_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [7:0]       symbol = 8'h00;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [7:0]       out_symbol;
    logic             has_symbol;
    logic             last_of_run;
    status_t          status;

    // Predictor state: operator stack and its fill level
    op_code_t         held_ops [0:STACK_DEPTH-1];
    int               held_count = 0;
    logic [2:0]       op_rank  [0:7] = '{3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd0};
    logic [7:0]       op_glyph [0:7] = '{CH_NUL, CH_OPEN, CH_HASH, CH_AT,
                                         CH_AMP, CH_SLASH, CH_CARET, CH_NUL};

    postfix_t         postfix_due [$];
    int               mismatch_count = 0;
    int               chars_sent = 0;
    int               chars_counted = 0;
    int               outputs_seen = 0;
    int               status_hits [0:7] = '{default: 0};
    int               cycle_count = 0;
    int               send_gap_pct = 0;
    int               sink_stall_pct = 0;
    int               hold_left = 0;

    infix_to_postfix_converter #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .symbol     (symbol),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_symbol (out_symbol),
        .has_symbol (has_symbol),
        .last_of_run(last_of_run),
        .status     (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d outputs still due",
                     cycle_count, postfix_due.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("MISMATCH %s: expected %0h, got %0h (output %0d, cycle %0d)",
                 what, want, got, outputs_seen, cycle_count);
        mismatch_count++;
    endtask

    function automatic bit is_alnum(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z");
    endfunction

    function automatic op_code_t oper_of(input logic [7:0] c);
        op_code_t k;
        k = CODE_NONE;
        if (c == CH_HASH)  k = CODE_HASH;
        if (c == CH_AT)    k = CODE_AT;
        if (c == CH_AMP)   k = CODE_AMP;
        if (c == CH_SLASH) k = CODE_SLASH;
        if (c == CH_CARET) k = CODE_CARET;
        return k;
    endfunction

    // Shunting-yard step: update the stack and queue the outputs this character causes
    task automatic predict_postfix(input logic [7:0] c);
        logic [7:0] emitted [$];
        status_t    st;
        op_code_t   k;
        bit         found;
        postfix_t   r;
        st = STS_OK;
        k = oper_of(c);
        found = 1'b0;
        if (c == CH_SPACE)
        begin
            // ignored
        end
        else if (is_alnum(c))
            emitted.push_back(c);
        else if (c == CH_OPEN)
        begin
            if (held_count >= STACK_DEPTH)
                st = STS_FULL;
            else
            begin
                held_ops[held_count] = CODE_OPEN;
                held_count++;
            end
        end
        else if (c == CH_CLOSE)
        begin
            for (int i = 0; i < held_count; i++)
                if (held_ops[i] == CODE_OPEN)
                    found = 1'b1;
            if (!found)
                st = STS_UNMATCHED;
            else
            begin
                while (held_ops[held_count-1] != CODE_OPEN)
                begin
                    held_count--;
                    emitted.push_back(op_glyph[held_ops[held_count]]);
                end
                held_count--;
            end
        end
        else if (k != CODE_NONE)
        begin
            // equal precedence pops too: left-associative throughout
            while (held_count > 0 && op_rank[held_ops[held_count-1]] >= op_rank[k])
            begin
                held_count--;
                emitted.push_back(op_glyph[held_ops[held_count]]);
            end
            if (held_count >= STACK_DEPTH)
                st = STS_FULL;
            else
            begin
                held_ops[held_count] = k;
                held_count++;
            end
        end
        else if (c == CH_NEWLINE)
        begin
            // flush; any open paren left behind is dropped and flagged
            while (held_count > 0)
            begin
                held_count--;
                if (held_ops[held_count] == CODE_OPEN)
                    st = STS_UNCLOSED;
                else
                    emitted.push_back(op_glyph[held_ops[held_count]]);
            end
            emitted.push_back(CH_NUL);
        end
        else
            st = STS_INVALID;

        if (emitted.size() == 0)
        begin
            r.sym = CH_NUL;
            r.has = 1'b0;
            r.last = 1'b1;
            r.st = st;
            postfix_due.push_back(r);
        end
        else
        begin
            foreach (emitted[i])
            begin
                r.sym = emitted[i];
                r.has = 1'b1;
                r.last = (i == emitted.size() - 1);
                r.st = st;
                postfix_due.push_back(r);
            end
        end
    endtask

    // Offer one character; called and returns at a falling edge
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        symbol = c;
        do
            @(posedge clk);
        while (in_stall);
        predict_postfix(c);
        chars_sent++;
        if (c != CH_SPACE)
            chars_counted++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // Sender holds off until every due output has been seen
    task automatic wait_drained();
        while (postfix_due.size() != 0)
            @(negedge clk);
    endtask

    // Output side: long hold-off when requested, else random stalls
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else
            out_stall = ($urandom_range(0, 99) < sink_stall_pct);
    end

    // Compare each accepted output against the oldest due one
    always @(posedge clk)
    begin : check_outputs
        postfix_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            outputs_seen++;
            if (postfix_due.size() == 0)
                report_mismatch("output with nothing due", 8'h00, out_symbol);
            else
            begin
                want = postfix_due.pop_front();
                if (out_symbol !== want.sym)
                    report_mismatch("out_symbol", want.sym, out_symbol);
                if (has_symbol !== want.has)
                    report_mismatch("has_symbol", 8'(want.has), 8'(has_symbol));
                if (last_of_run !== want.last)
                    report_mismatch("last_of_run", 8'(want.last), 8'(last_of_run));
                if (status !== want.st)
                    report_mismatch("status", 8'(want.st), 8'(status));
                if (last_of_run === 1'b1 && status !== 3'bx)
                    status_hits[status]++;
            end
        end
    end

    function automatic logic [7:0] rand_operand();
        case ($urandom_range(0, 2))
            0:       return 8'("0" + $urandom_range(0, 9));
            1:       return 8'("A" + $urandom_range(0, 25));
            default: return 8'("a" + $urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] rand_operator();
        case ($urandom_range(0, 4))
            0:       return CH_HASH;
            1:       return CH_AT;
            2:       return CH_AMP;
            3:       return CH_SLASH;
            default: return CH_CARET;
        endcase
    endfunction

    // Well-formed expression with random content; now and then left broken
    task automatic send_expression();
        int terms;
        int opens;
        terms = $urandom_range(1, 8);
        opens = 0;
        for (int t = 0; t < terms; t++)
        begin
            while (opens < 12 && $urandom_range(0, 3) == 0)
            begin
                send_char(CH_OPEN);
                opens++;
            end
            send_char(rand_operand());
            while (opens > 0 && $urandom_range(0, 2) == 0)
            begin
                send_char(CH_CLOSE);
                opens--;
            end
            if (t != terms - 1)
                send_char(rand_operator());
            if ($urandom_range(0, 5) == 0)
                send_char(CH_SPACE);
        end
        if ($urandom_range(0, 9) != 0)
        begin
            while (opens > 0)
            begin
                send_char(CH_CLOSE);
                opens--;
            end
        end
        else if ($urandom_range(0, 1) == 0)
            send_char(CH_CLOSE);
        send_char(CH_NEWLINE);
    endtask

    // Noise: raw bytes over the whole range, stray closes, lone operators
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 3))
                0:       send_char(CH_CLOSE);
                1:       send_char(rand_operator());
                default: send_char(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // Every operator, parentheses, space and the alphanumerics A, z, 0 and 9
    task automatic test_directed_ops();
        send_text("Az09 (a#b)^c^d&e/f@g");
        send_char(CH_NEWLINE);
        wait_drained();
    endtask

    // Unmatched close, invalid bytes, unclosed open, empty line
    task automatic test_directed_corners();
        send_char(CH_CLOSE);
        send_char(8'hFF);
        send_char(8'h00);
        send_char(8'h80);
        send_text("(a");
        send_char(CH_NEWLINE);
        send_char(CH_NEWLINE);
        wait_drained();
    endtask

    // Fill the stack with open parens, then hit it with '(', operators, ')' and a newline
    task automatic test_stack_full();
        for (int i = 0; i < STACK_DEPTH; i++)
            send_char(CH_OPEN);
        send_char(CH_OPEN);
        send_char(CH_CARET);
        send_char(CH_CLOSE);
        send_char(CH_HASH);
        send_char(CH_CARET);
        send_char(CH_AMP);
        send_char(CH_NEWLINE);
        wait_drained();
    endtask

    task automatic test_random_phase(input int gap_pct, input int stall_pct,
                                     input int count);
        int stop_at;
        send_gap_pct = gap_pct;
        sink_stall_pct = stall_pct;
        stop_at = chars_counted + count;
        while (chars_counted < stop_at)
        begin
            if ($urandom_range(0, 99) < 85)
                send_expression();
            else
                send_noise();
        end
        wait_drained();
    endtask

    // Output held off for a long stretch while input keeps coming
    task automatic test_long_hold();
        @(posedge clk);
        hold_left = LONG_HOLD;
        @(negedge clk);
        for (int i = 0; i < 4; i++)
            send_expression();
        wait_drained();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_gap_pct = 35;
        sink_stall_pct = 74;
        test_directed_ops();
        test_directed_corners();
        test_stack_full();
        test_random_phase(35, 74, 90);
        test_random_phase(74, 35, 90);
        send_gap_pct = 0;
        sink_stall_pct = 0;
        test_long_hold();
        test_random_phase(0, 0, 70);

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (postfix_due.size() != 0)
            report_mismatch("outputs never seen", 8'(postfix_due.size()), 8'h00);

        $display("run covered %0d input characters and %0d postfix outputs over %0d cycles",
                 chars_sent, outputs_seen, cycle_count);
        $display("runs by status: ok %0d, full %0d, unmatched %0d, invalid %0d, unclosed %0d",
                 status_hits[STS_OK], status_hits[STS_FULL], status_hits[STS_UNMATCHED],
                 status_hits[STS_INVALID], status_hits[STS_UNCLOSED]);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/i2p_pkg.sv
sv/infix_to_postfix_converter.sv
tb/sv/testbench.sv
